>>> rtl/ths_pkg.sv
// Shared types, constants and helper functions for the tilt heading smoother.
package ths_pkg;

    localparam int unsigned ITERS     = 16;
    localparam int unsigned ITER_W    = $clog2(ITERS);
    localparam int unsigned ANGLE_W   = 25;
    localparam int unsigned WEIGHT_W  = 16;
    localparam int unsigned TENTHS_W  = 12;
    localparam int unsigned VEC_W     = 33;
    localparam int unsigned ZACC_W    = 27;
    localparam int unsigned IN_SHIFT  = 14;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd13107;
    localparam logic signed [ZACC_W-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [ZACC_W-1:0] DEG360 = 27'sd23592960;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic               read_failed;
    } in_word_t;

    typedef struct packed {
        logic [TENTHS_W-1:0] smoothed_tenths;
        logic [TENTHS_W-1:0] raw_tenths;
        logic                status;
    } out_word_t;

    typedef struct packed {
        logic              load;
        logic              iterate;
        logic [ITER_W-1:0] iter_idx;
        logic              fold;
        logic              mul_new;
        logic              mul_old;
        logic              emit;
    } ctl_cmd_t;

    // Arctangent of 2^-i in Q9.16 degrees, rounded to nearest.
    function automatic logic [21:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [21:0] val;
        begin
            unique case (idx)
                4'd0:    val = 22'd2949120;
                4'd1:    val = 22'd1740967;
                4'd2:    val = 22'd919879;
                4'd3:    val = 22'd466945;
                4'd4:    val = 22'd234379;
                4'd5:    val = 22'd117304;
                4'd6:    val = 22'd58666;
                4'd7:    val = 22'd29335;
                4'd8:    val = 22'd14668;
                4'd9:    val = 22'd7334;
                4'd10:   val = 22'd3667;
                4'd11:   val = 22'd1833;
                4'd12:   val = 22'd917;
                4'd13:   val = 22'd458;
                4'd14:   val = 22'd229;
                4'd15:   val = 22'd115;
                default: val = 22'd0;
            endcase
            return val;
        end
    endfunction

    // Angle in Q9.16 degrees to tenths of a degree, truncated.
    function automatic logic [TENTHS_W-1:0] to_tenths(input logic [ANGLE_W-1:0] q);
        logic [ANGLE_W+3:0] t;
        begin
            t = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
            return t[TENTHS_W+15:16];
        end
    endfunction

endpackage

>>> rtl/tilt_heading_smoother_unit.sv
// Top level of the tilt heading smoother: controller, datapath and checks.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid / in_stall    | accel_x, accel_y, read_failed
//   out     | output    | out_valid / out_stall  | smoothed_tenths, raw_tenths, status
//   cfg     | input     | cfg_valid / cfg_ready  | smoothing weight, Q0.16
//
// A good sample runs through the 16 CORDIC iterations of the shared shift-add unit,
// a fold and the two blend multiplies before its word is emitted; no new sample is accepted meanwhile.
// A failed read skips the angle work and goes straight to the emit state.
// Reset clears the smoothed angle and loads the weight with 0.2.
// The finished word waits in the output register while out_stall is high; a new
// sample is accepted meanwhile, but its result is held back until that word goes.
module tilt_heading_smoother_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ths_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ths_pkg::out_word_t            out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ths_pkg::WEIGHT_W-1:0]  cfg_data
);

    ths_pkg::ctl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ths_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .read_failed (in_word.read_failed),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    ths_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (in_word),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .out_word (out_word)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("sequencer took no work after accepting a word");

    a_error_has_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status |-> out_word.raw_tenths == '0)
        else $error("error word carries a raw angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.smoothed_tenths < 12'd3600 && out_word.raw_tenths < 12'd3600)
        else $error("angle out of range");

endmodule

>>> rtl/ths_ctrl.sv
// Sequencing state machine for the tilt heading smoother.
module ths_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              read_failed,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output ths_pkg::ctl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ITER = 6'b000010,
        S_FOLD = 6'b000100,
        S_MULN = 6'b001000,
        S_MULO = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [ths_pkg::ITER_W-1:0]  iter_reg, iter_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.iter_idx   = iter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                iter_next = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = read_failed ? S_EMIT : S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.iterate = 1'b1;
                iter_next   = iter_reg + 1'b1;
                if (iter_reg == ths_pkg::ITER_W'(ths_pkg::ITERS - 1))
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_MULN;
            end
            S_MULN:
            begin
                cmd.mul_new = 1'b1;
                state_next  = S_MULO;
            end
            S_MULO:
            begin
                cmd.mul_old = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/ths_datapath.sv
// CORDIC vectoring unit, blend multipliers and result register of the smoother.
module ths_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ths_pkg::ctl_cmd_t                cmd,
    input  ths_pkg::in_word_t                in_word,
    input  logic                             cfg_we,
    input  logic [ths_pkg::WEIGHT_W-1:0]     cfg_data,
    output ths_pkg::out_word_t               out_word
);

    localparam int unsigned VW = ths_pkg::VEC_W;
    localparam int unsigned ZW = ths_pkg::ZACC_W;
    localparam int unsigned AW = ths_pkg::ANGLE_W;
    localparam int unsigned WW = ths_pkg::WEIGHT_W;
    localparam int unsigned PW = AW + WW;

    logic signed [VW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic                  zero_reg, zero_next;
    logic                  fail_reg, fail_next;
    logic [AW-1:0]         raw_reg, raw_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [AW-1:0]         smooth_reg, smooth_next;
    logic [WW-1:0]         weight_reg, weight_next;
    ths_pkg::out_word_t    out_reg, out_next;

    logic signed [VW-1:0]  xs, ys, dx, dy;
    logic signed [ZW-1:0]  zstep, zfold;
    logic [WW:0]           inv_weight;
    logic [PW:0]           acc;

    function automatic logic signed [VW-1:0] shr_tz(input logic signed [VW-1:0] v,
                                                    input logic [ths_pkg::ITER_W-1:0] s);
        logic signed [VW-1:0] mag;
        logic signed [VW-1:0] sh;
        begin
            mag = v[VW-1] ? -v : v;
            sh  = mag >>> s;
            return v[VW-1] ? -sh : sh;
        end
    endfunction

    always_comb
    begin
        xs = VW'(in_word.accel_x) <<< ths_pkg::IN_SHIFT;
        ys = VW'(in_word.accel_y) <<< ths_pkg::IN_SHIFT;
        dx = shr_tz(y_reg, cmd.iter_idx);
        dy = shr_tz(x_reg, cmd.iter_idx);
        zstep = ZW'(signed'({1'b0, ths_pkg::atan_entry(cmd.iter_idx)}));
        zfold = z_reg[ZW-1] ? z_reg + ths_pkg::DEG360 : z_reg;
        inv_weight = (WW+1)'(1 << WW) - {1'b0, weight_reg};
        acc = {1'b0, prod_reg} + (PW+1)'(inv_weight * smooth_reg);

        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        zero_next   = zero_reg;
        fail_next   = fail_reg;
        raw_next    = raw_reg;
        prod_next   = prod_reg;
        smooth_next = smooth_reg;
        weight_next = cfg_we ? cfg_data : weight_reg;
        out_next    = out_reg;

        if (cmd.load)
        begin
            fail_next = in_word.read_failed;
            zero_next = (in_word.accel_x == '0) && (in_word.accel_y == '0);
            if (xs[VW-1])
            begin
                x_next = -xs;
                y_next = -ys;
                z_next = ths_pkg::DEG180;
            end
            else
            begin
                x_next = xs;
                y_next = ys;
                z_next = '0;
            end
        end
        if (cmd.iterate)
        begin
            if (!y_reg[VW-1])
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + zstep;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - zstep;
            end
        end
        if (cmd.fold)
        begin
            raw_next = zero_reg ? '0 : zfold[AW-1:0];
        end
        if (cmd.mul_new)
        begin
            prod_next = PW'(weight_reg * raw_reg);
        end
        if (cmd.mul_old)
        begin
            smooth_next = acc[PW-1:WW];
        end
        if (cmd.emit)
        begin
            out_next.smoothed_tenths = ths_pkg::to_tenths(smooth_reg);
            out_next.raw_tenths      = fail_reg ? '0 : ths_pkg::to_tenths(raw_reg);
            out_next.status          = fail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
            weight_reg <= ths_pkg::WEIGHT_RESET;
        end
        else
        begin
            smooth_reg <= smooth_next;
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        fail_reg <= fail_next;
        raw_reg  <= raw_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign out_word = out_reg;

endmodule

>>> tb/tilt_heading_smoother_unit_test.sv
// Self-checking testbench for the tilt heading smoother: CORDIC heading and blend predictor.
`timescale 1ns / 100ps

module tilt_heading_smoother_unit_test;

    localparam int CLK_PERIOD   = 12;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int CORDIC_STEPS = 16;
    localparam longint HALF_TURN = 64'sd11796480;
    localparam longint FULL_TURN = 64'sd23592960;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_mode_t;

    localparam longint ARCTAN_Q16 [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    ths_pkg::in_word_t  in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    ths_pkg::out_word_t out_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ths_pkg::WEIGHT_W-1:0] cfg_data = '0;

    logic [ths_pkg::WEIGHT_W-1:0] model_weight = ths_pkg::WEIGHT_RESET;
    logic [ths_pkg::ANGLE_W-1:0]  model_smoothed = '0;
    ths_pkg::out_word_t           expected_words[$];
    int                           mismatch_count = 0;
    int                           words_checked = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          hold_request = 0;
    bit          pacing_on = 1'b1;
    int          burst_left = 1;

    tilt_heading_smoother_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #6ms;
        $display("tilt_heading_smoother_unit regression: fail");
        $finish;
    end

    function automatic longint shift_toward_zero(longint v, int s);
        return (v >= 0) ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic logic [ths_pkg::ANGLE_W-1:0] heading_of(logic signed [15:0] ax,
                                                               logic signed [15:0] ay);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(ax);
        y = longint'(ay);
        z = 0;
        if (x == 0 && y == 0)
        begin
            return '0;
        end
        x = x * 16384;
        y = y * 16384;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = shift_toward_zero(y, i);
            dy = shift_toward_zero(x, i);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q16[i];
            end
        end
        if (z < 0)
        begin
            z = z + FULL_TURN;
        end
        return z[ths_pkg::ANGLE_W-1:0];
    endfunction

    function automatic logic [ths_pkg::TENTHS_W-1:0] tenths_of(
        logic [ths_pkg::ANGLE_W-1:0] q);
        longint t;
        t = longint'(q) * 10;
        return t[ths_pkg::TENTHS_W+15:16];
    endfunction

    // Advances the smoothed heading on a good read and returns the word the block must produce.
    function automatic ths_pkg::out_word_t predict_heading_word(ths_pkg::in_word_t w);
        ths_pkg::out_word_t r;
        logic [ths_pkg::ANGLE_W-1:0] raw;
        longint acc;
        if (w.read_failed)
        begin
            r.smoothed_tenths = tenths_of(model_smoothed);
            r.raw_tenths = '0;
            r.status = 1'b1;
            return r;
        end
        raw = heading_of(w.accel_x, w.accel_y);
        acc = longint'(model_weight) * longint'(raw)
            + longint'(65536 - int'(model_weight)) * longint'(model_smoothed);
        model_smoothed = acc[ths_pkg::ANGLE_W+15:16];
        r.smoothed_tenths = tenths_of(model_smoothed);
        r.raw_tenths = tenths_of(raw);
        r.status = 1'b0;
        return r;
    endfunction

    function automatic ths_pkg::in_word_t make_sample(int x, int y, bit failed);
        ths_pkg::in_word_t w;
        w.accel_x = x[15:0];
        w.accel_y = y[15:0];
        w.read_failed = failed;
        return w;
    endfunction

    function automatic int pick_axis();
        int r;
        int corners [5] = '{-32768, 32767, 0, 1, -1};
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return corners[$urandom_range(0, 4)];
        end
        if (r == 1)
        begin
            return int'($urandom_range(0, 16)) - 8;
        end
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic ths_pkg::in_word_t random_sample();
        int x;
        int y;
        bit failed;
        x = pick_axis();
        y = pick_axis();
        failed = ($urandom_range(0, 19) < 2);
        return make_sample(x, y, failed);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on word %0d: %s got %0d expected %0d",
                 words_checked, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        ths_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word", int'(out_word), 0);
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_word.smoothed_tenths !== want.smoothed_tenths)
                    report_mismatch("smoothed_tenths", int'(out_word.smoothed_tenths),
                                    int'(want.smoothed_tenths));
                if (out_word.raw_tenths !== want.raw_tenths)
                    report_mismatch("raw_tenths", int'(out_word.raw_tenths),
                                    int'(want.raw_tenths));
                if (out_word.status !== want.status)
                    report_mismatch("status", int'(out_word.status), int'(want.status));
            end
            words_checked++;
        end
    end

    // Receiver back-pressure; a hold request forces a long stall counted here.
    always @(posedge clk)
    begin
        static int hold_seen = 0;
        static int hold_left = 0;
        static int cycle_count = 0;
        cycle_count++;
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            unique case (stall_mode)
                STALL_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:   out_stall <= ($urandom_range(0, 9) < 7);
                STALL_PATTERN: out_stall <= ((cycle_count % 11) < 4);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    task automatic pause_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_sample(ths_pkg::in_word_t w);
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (in_stall);
        expected_words.push_back(predict_heading_word(w));
    endtask

    task automatic send_paced(ths_pkg::in_word_t w);
        int gap;
        send_sample(w);
        if (pacing_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 6);
                if (gap > 0)
                    pause_input(gap);
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_weight(logic [ths_pkg::WEIGHT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_weight = value;
        @(posedge clk);
    endtask

    task automatic test_directed_cases();
        ths_pkg::in_word_t list[$];
        stall_mode = STALL_NONE;
        pacing_on = 1'b0;
        list.push_back(make_sample(0, 0, 1'b0));
        list.push_back(make_sample(32767, 0, 1'b0));
        list.push_back(make_sample(-32768, 0, 1'b0));
        list.push_back(make_sample(0, 32767, 1'b0));
        list.push_back(make_sample(0, -32768, 1'b0));
        list.push_back(make_sample(32767, 32767, 1'b0));
        list.push_back(make_sample(-32768, -32768, 1'b0));
        list.push_back(make_sample(-32768, 32767, 1'b0));
        list.push_back(make_sample(32767, -32768, 1'b0));
        list.push_back(make_sample(-1, -1, 1'b1));
        list.push_back(make_sample(1, 0, 1'b0));
        list.push_back(make_sample(-1, 0, 1'b0));
        list.push_back(make_sample(0, 1, 1'b0));
        list.push_back(make_sample(0, -1, 1'b0));
        list.push_back(make_sample(-1, -1, 1'b0));
        list.push_back(make_sample(1, -1, 1'b0));
        list.push_back(make_sample(0, 0, 1'b1));
        list.push_back(make_sample(-32768, -1, 1'b0));
        list.push_back(make_sample(0, 0, 1'b0));
        foreach (list[i])
            send_paced(list[i]);
        drain_results();
    endtask

    task automatic test_weight_extremes();
        logic [ths_pkg::WEIGHT_W-1:0] weights [4] = '{16'd0, 16'd65535, 16'd1, 16'd32768};
        stall_mode = STALL_LIGHT;
        pacing_on = 1'b1;
        foreach (weights[k])
        begin
            write_weight(weights[k]);
            send_paced(make_sample(-32768, 1, 1'b0));
            send_paced(make_sample(0, 0, 1'b0));
            send_paced(make_sample(12345, -3210, 1'b1));
            repeat (8) send_paced(random_sample());
        end
    endtask

    task automatic test_random_traffic();
        stall_mode_t modes [6] = '{STALL_NONE, STALL_LIGHT, STALL_HEAVY,
                                   STALL_PATTERN, STALL_LIGHT, STALL_NONE};
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
                write_weight(16'd65535);
            else
                write_weight(ths_pkg::WEIGHT_W'($urandom_range(0, 65535)));
            stall_mode = modes[phase];
            pacing_on = (phase != 0) && (phase != 5);
            repeat (230) send_paced(random_sample());
        end
    endtask

    task automatic test_backpressure();
        write_weight(ths_pkg::WEIGHT_W'($urandom_range(0, 65535)));
        stall_mode = STALL_NONE;
        pacing_on = 1'b0;
        hold_request++;
        repeat (40) send_paced(random_sample());
        drain_results();
        stall_mode = STALL_HEAVY;
        pacing_on = 1'b1;
        repeat (20) send_paced(random_sample());
    endtask

    task automatic test_default_weight_return();
        write_weight(ths_pkg::WEIGHT_RESET);
        stall_mode = STALL_PATTERN;
        pacing_on = 1'b1;
        repeat (120) send_paced(random_sample());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_weight_extremes();
        test_random_traffic();
        test_backpressure();
        test_default_weight_return();
        drain_results();
        if (mismatch_count == 0)
            $display("tilt_heading_smoother_unit regression: pass");
        else
            $display("tilt_heading_smoother_unit regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/ths_pkg.sv
rtl/ths_ctrl.sv
rtl/ths_datapath.sv
rtl/tilt_heading_smoother_unit.sv
tb/tilt_heading_smoother_unit_test.sv
